// ===== hdl/arma_iir_filter_macros.svh =====
// ============================================================================
// ARMA filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ARMA_IIR_FILTER_MACROS_SVH
`define ARMA_IIR_FILTER_MACROS_SVH

// When the condition holds, the expression must hold in the same cycle.
`define ARMA_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("arma_iir_filter: same-cycle check failed");

// When the condition holds, the expression must hold in the next cycle.
`define ARMA_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("arma_iir_filter: next-cycle check failed");

`endif

// ===== hdl/arma_pkg.sv =====
// ============================================================================
// ARMA filter package
// Shared types, codes and default sizes for the direct-form-I IIR filter.
// ============================================================================
`default_nettype none

package arma_pkg;

    // Default configuration of the filter.
    localparam int MAX_TAPS_DEFAULT     = 16;
    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int COEF_WIDTH_DEFAULT   = 18;

    // Fixed field widths.
    localparam int ACC_WIDTH        = 64;
    localparam int TAP_COUNT_WIDTH  = 5;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int COEF_INDEX_WIDTH = 4;
    localparam int OP_WIDTH         = 2;

    // Operation codes carried by an input word.
    typedef enum logic [OP_WIDTH-1:0] {
        OP_FILTER    = 2'd0,
        OP_WRITE_FWD = 2'd1,
        OP_WRITE_FB  = 2'd2
    } op_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FORWARD_TAPS  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_TAPS = 2'd1;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic valid;     // operands are present this cycle
        logic subtract;  // product is a feedback term
        logic clear;     // start a new sum
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/arma_mac.sv =====
// ============================================================================
// ARMA filter multiply-accumulate unit
// One registered signed multiplier followed by an exact 64-bit accumulator.
// ============================================================================
`default_nettype none

module arma_mac #(
    parameter int SAMPLE_WIDTH = arma_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_WIDTH   = arma_pkg::COEF_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire arma_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       op_x,
    input  wire logic signed [COEF_WIDTH-1:0]         op_c,
    output logic signed [arma_pkg::ACC_WIDTH-1:0]     acc,
    output logic                                      busy
);

    localparam int ProdWidth = SAMPLE_WIDTH + COEF_WIDTH;

    logic signed [ProdWidth-1:0]           prod_reg;
    logic                                  prod_valid_reg;
    logic                                  prod_sub_reg;
    logic signed [arma_pkg::ACC_WIDTH-1:0] acc_reg;
    logic signed [arma_pkg::ACC_WIDTH-1:0] prod_ext;

    // Product stage: payload only.
    always_ff @(posedge clk)
    begin
        prod_reg     <= ProdWidth'(op_x) * ProdWidth'(op_c);
        prod_sub_reg <= ctrl.subtract;
    end

    // Product valid flag and the running sum.
    assign prod_ext = arma_pkg::ACC_WIDTH'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= prod_sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/arma_iir_filter.sv =====
// ============================================================================
// ARMA filter top level
// Direct-form-I IIR filter with one shared multiply-accumulate unit.
// ============================================================================
//
// Channel   Direction  Handshake              Word
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in         in_valid/in_ready      operation, coef_index, coef_value, sample_in
// out       out        out_valid/out_ready    sample_out, saturated
//
// A sample word passes its terms one by one through the single multiplier and
// accumulator: F forward terms, then feedback terms 1 to B-1 (F, B the clamped
// tap counts), then a two-stage drain, rounding and the output write, all before
// the next word is accepted. Coefficient writes and unused operations give no output word.
// Reset clears tap counts, the ring pointer and the valid bits of all four tables.
// The input side takes a new word while a finished output word waits to be taken;
// the sequencer only holds its last step until the output register is free.
`default_nettype none

`include "arma_iir_filter_macros.svh"

module arma_iir_filter #(
    parameter int MAX_TAPS     = arma_pkg::MAX_TAPS_DEFAULT,
    parameter int SAMPLE_WIDTH = arma_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_WIDTH   = arma_pkg::COEF_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [arma_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [arma_pkg::TAP_COUNT_WIDTH-1:0]   cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [arma_pkg::OP_WIDTH-1:0]          operation,
    input  wire logic [arma_pkg::COEF_INDEX_WIDTH-1:0]  coef_index,
    input  wire logic signed [COEF_WIDTH-1:0]           coef_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         sample_in,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]              sample_out,
    output logic                                        saturated
);

    localparam int AddrWidth  = $clog2(MAX_TAPS);
    localparam int CountWidth = $clog2(MAX_TAPS + 1);
    localparam int Shift      = COEF_WIDTH - 2;
    localparam int AccWidth   = arma_pkg::ACC_WIDTH;

    localparam logic signed [AccWidth-1:0] Half    = AccWidth'(1) <<< (Shift - 1);
    localparam logic signed [AccWidth-1:0] MaxPos  = (AccWidth'(1) <<< (SAMPLE_WIDTH - 1))
                                                     - AccWidth'(1);
    localparam logic signed [AccWidth-1:0] MinNeg  = -MaxPos - AccWidth'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FWD,
        S_FB,
        S_DRAIN,
        S_ROUND,
        S_DONE
    } state_t;

    // Control state.
    state_t                                  state_reg;
    logic [CountWidth-1:0]                   k_reg;
    logic [AddrWidth-1:0]                    ptr_reg;
    logic [arma_pkg::TAP_COUNT_WIDTH-1:0]    fwd_taps_reg;
    logic [arma_pkg::TAP_COUNT_WIDTH-1:0]    fb_taps_reg;
    logic                                    out_valid_reg;
    logic                                    op_valid_reg;
    logic [MAX_TAPS-1:0]                     x_valid_reg;
    logic [MAX_TAPS-1:0]                     y_valid_reg;
    logic [MAX_TAPS-1:0]                     fc_valid_reg;
    logic [MAX_TAPS-1:0]                     bc_valid_reg;

    // Tables and payload registers.
    logic signed [SAMPLE_WIDTH-1:0]          x_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0]          y_mem [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]            fc_mem [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]            bc_mem [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0]          opx_reg;
    logic signed [COEF_WIDTH-1:0]            opc_reg;
    logic                                    op_sub_reg;
    logic signed [AccWidth-1:0]              t_reg;
    logic signed [SAMPLE_WIDTH-1:0]          sample_out_reg;
    logic                                    saturated_reg;

    // Combinational signals.
    arma_pkg::op_t                           op;
    arma_pkg::mac_ctrl_t                     mac_ctrl;
    logic signed [AccWidth-1:0]              acc;
    logic                                    mac_busy;
    logic                                    in_fire;
    logic                                    coef_ok;
    logic [AddrWidth-1:0]                    coef_addr;
    logic [CountWidth-1:0]                   nf;
    logic [CountWidth-1:0]                   nb;
    logic                                    issue_fwd;
    logic                                    issue_fb;
    logic [AddrWidth:0]                      ring_sum;
    logic [AddrWidth-1:0]                    ring_addr;
    logic [AddrWidth-1:0]                    k_addr;
    logic                                    done_fire;
    logic signed [AccWidth-1:0]              q;
    logic                                    sat_hi;
    logic                                    sat_lo;
    logic signed [SAMPLE_WIDTH-1:0]          res;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign op        = arma_pkg::op_t'(operation);
    assign done_fire = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Coefficient address; positions past the table are dropped.
    assign coef_ok   = int'(coef_index) < MAX_TAPS;
    assign coef_addr = AddrWidth'(coef_index);

    // Tap counts saturate at the table depth.
    assign nf = (int'(fwd_taps_reg) > MAX_TAPS) ? CountWidth'(MAX_TAPS)
                                                 : CountWidth'(fwd_taps_reg);
    assign nb = (int'(fb_taps_reg) > MAX_TAPS) ? CountWidth'(MAX_TAPS)
                                                : CountWidth'(fb_taps_reg);

    // Term issue and ring addressing: the entry k samples back is at pointer plus k.
    assign issue_fwd = (state_reg == S_FWD) && (k_reg < nf);
    assign issue_fb  = (state_reg == S_FB) && (k_reg < nb);
    assign k_addr    = k_reg[AddrWidth-1:0];
    assign ring_sum  = {1'b0, ptr_reg} + {1'b0, k_addr};
    assign ring_addr = (ring_sum >= (AddrWidth + 1)'(MAX_TAPS))
                       ? AddrWidth'(ring_sum - (AddrWidth + 1)'(MAX_TAPS))
                       : ring_sum[AddrWidth-1:0];

    // Control to the multiply-accumulate unit.
    assign mac_ctrl.valid    = op_valid_reg;
    assign mac_ctrl.subtract = op_sub_reg;
    assign mac_ctrl.clear    = in_fire && (op == arma_pkg::OP_FILTER);

    arma_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_x  (opx_reg),
        .op_c  (opc_reg),
        .acc   (acc),
        .busy  (mac_busy)
    );

    // Floor shift of the rounded sum, then saturation to the sample range.
    assign q      = t_reg >>> Shift;
    assign sat_hi = q > MaxPos;
    assign sat_lo = q < MinNeg;
    assign res    = sat_hi ? MaxPos[SAMPLE_WIDTH-1:0]
                  : sat_lo ? MinNeg[SAMPLE_WIDTH-1:0]
                  : q[SAMPLE_WIDTH-1:0];

    // Table writes, operand reads and result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            unique case (op)
                arma_pkg::OP_FILTER:
                begin
                    x_mem[ptr_reg] <= sample_in;
                end
                arma_pkg::OP_WRITE_FWD:
                begin
                    if (coef_ok)
                    begin
                        fc_mem[coef_addr] <= coef_value;
                    end
                end
                arma_pkg::OP_WRITE_FB:
                begin
                    if (coef_ok)
                    begin
                        bc_mem[coef_addr] <= coef_value;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (issue_fwd)
        begin
            opx_reg <= x_valid_reg[ring_addr] ? x_mem[ring_addr] : '0;
            opc_reg <= fc_valid_reg[k_addr] ? fc_mem[k_addr] : '0;
        end
        else
        begin
            opx_reg <= y_valid_reg[ring_addr] ? y_mem[ring_addr] : '0;
            opc_reg <= bc_valid_reg[k_addr] ? bc_mem[k_addr] : '0;
        end
        op_sub_reg <= issue_fb;

        if (state_reg == S_ROUND)
        begin
            t_reg <= acc + Half;
        end

        if (done_fire)
        begin
            y_mem[ptr_reg] <= res;
            sample_out_reg <= res;
            saturated_reg  <= sat_hi || sat_lo;
        end
    end

    // Sequencer, configuration registers, valid bits and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            ptr_reg       <= '0;
            fwd_taps_reg  <= '0;
            fb_taps_reg   <= '0;
            out_valid_reg <= 1'b0;
            op_valid_reg  <= 1'b0;
            x_valid_reg   <= '0;
            y_valid_reg   <= '0;
            fc_valid_reg  <= '0;
            bc_valid_reg  <= '0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    arma_pkg::REG_FORWARD_TAPS:  fwd_taps_reg <= cfg_data;
                    arma_pkg::REG_FEEDBACK_TAPS: fb_taps_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // Output valid: set by a finished result, cleared once the word is taken.
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            op_valid_reg <= issue_fwd || issue_fb;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (op)
                            arma_pkg::OP_FILTER:
                            begin
                                x_valid_reg[ptr_reg] <= 1'b1;
                                k_reg                <= '0;
                                state_reg            <= S_FWD;
                            end
                            arma_pkg::OP_WRITE_FWD:
                            begin
                                if (coef_ok)
                                begin
                                    fc_valid_reg[coef_addr] <= 1'b1;
                                end
                            end
                            arma_pkg::OP_WRITE_FB:
                            begin
                                if (coef_ok)
                                begin
                                    bc_valid_reg[coef_addr] <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_FWD:
                begin
                    if (issue_fwd)
                    begin
                        k_reg <= k_reg + CountWidth'(1);
                    end
                    else
                    begin
                        // Feedback coefficient 0 is never used.
                        k_reg     <= CountWidth'(1);
                        state_reg <= S_FB;
                    end
                end
                S_FB:
                begin
                    if (issue_fb)
                    begin
                        k_reg <= k_reg + CountWidth'(1);
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!op_valid_reg && !mac_busy)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        y_valid_reg[ptr_reg] <= 1'b1;
                        ptr_reg              <= (ptr_reg == '0) ? AddrWidth'(MAX_TAPS - 1)
                                                                : ptr_reg - AddrWidth'(1);
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

    // Nothing is in flight in the multiply-accumulate path while idle.
    `ARMA_ASSERT_SAME(a_idle_quiet, state_reg == S_IDLE, !op_valid_reg && !mac_busy)
    // Rounding only starts once every product has reached the sum.
    `ARMA_ASSERT_SAME(a_round_drained, state_reg == S_ROUND, !op_valid_reg && !mac_busy)
    // The ring pointer moves only when a result is written out.
    `ARMA_ASSERT_NEXT(a_ptr_hold, !done_fire, $stable(ptr_reg))

endmodule

`default_nettype wire
